[rtl/core/wide_immediate_materializer_core_macros.svh]
// Assertion macros used by the checker file of the materializer core.
`ifndef WIDE_IMMEDIATE_MATERIALIZER_CORE_MACROS_SVH
`define WIDE_IMMEDIATE_MATERIALIZER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and muted while rst is high.
`define WIM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and muted while rst is high.
`define WIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wim_pkg.sv]
// Shared types and codes of the wide immediate materializer core.
`default_nettype none

package wim_pkg;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned PIECE_W   = 16;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned REG_W     = 5;
  localparam int unsigned NPIECES   = 4;
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 72;
  localparam int unsigned M_TUSER_W = 3;
  localparam int unsigned CFG_ADDR_W = 2;

  // Instruction kinds on the result stream.
  localparam logic [1:0] OP_MOVZ = 2'd0;
  localparam logic [1:0] OP_MOVN = 2'd1;
  localparam logic [1:0] OP_MOVK = 2'd2;
  localparam logic [1:0] OP_ORR  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_ALLOW_INV = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ALLOW_ORR = 2'd1;

  // One classified constant as it waits between the front and back ends.
  typedef struct packed {
    logic [VALUE_W-1:0] value;   // already truncated to the register width
    logic               wide;
    logic [REG_W-1:0]   dreg;
    logic               use_orr;
    logic               inv;
    logic [SLOT_W-1:0]  first;
    logic [NPIECES-1:0] keep_mask; // pieces that still need a move-keep
  } entry_t;

endpackage

`default_nettype wire

[rtl/core/wim_front.sv]
// Front end: truncates the constant, prices both seeds and checks the bitmask form.
`default_nettype none

module wim_front (
  input  wire logic [wim_pkg::VALUE_W-1:0] value_in,
  input  wire logic                        wide,
  input  wire logic [wim_pkg::REG_W-1:0]   dreg,
  input  wire logic                        allow_inv,
  input  wire logic                        allow_orr,
  output wim_pkg::entry_t                  entry
);

  // A value is a bitmask immediate when it is periodic with some element size e
  // and its cyclic bit transitions number exactly two per element.
  function automatic logic bitmask_imm(input logic [63:0] v, input logic w);
    logic [63:0] r64;
    logic [31:0] v32;
    logic [31:0] r32;
    logic [6:0]  t;
    logic        hit;
    int          k;
    hit = 1'b0;
    v32 = v[31:0];
    if (w) begin
      t = 7'($countones(v ^ {v[62:0], v[63]}));
      for (k = 1; k <= 6; k++) begin
        r64 = (v << (1 << k)) | (v >> (64 - (1 << k)));
        if (r64 == v && t == 7'(128 >> k)) hit = 1'b1;
      end
      hit = hit && (v != '0) && (v != '1);
    end else begin
      t = 7'($countones(v32 ^ {v32[30:0], v32[31]}));
      for (k = 1; k <= 5; k++) begin
        r32 = (v32 << (1 << k)) | (v32 >> (32 - (1 << k)));
        if (r32 == v32 && t == 7'(64 >> k)) hit = 1'b1;
      end
      hit = hit && (v32 != '0) && (v32 != '1);
    end
    return hit;
  endfunction

  logic [wim_pkg::VALUE_W-1:0] value;
  logic [wim_pkg::NPIECES-1:0] nz_flags;
  logic [wim_pkg::NPIECES-1:0] nones_flags;
  logic [wim_pkg::NPIECES-1:0] sel;
  logic [2:0]                  nz;
  logic [2:0]                  nones;
  logic [2:0]                  zcost;
  logic [2:0]                  ncost;
  logic [2:0]                  cost;
  logic                        inv;
  logic                        use_orr;
  logic [wim_pkg::SLOT_W-1:0]  first;
  logic                        found;

  always_comb begin
    value = wide ? value_in : {32'd0, value_in[31:0]};
    for (int i = 0; i < wim_pkg::NPIECES; i++) begin
      nz_flags[i]    = (wide || i < 2) && (value[i*16 +: 16] != 16'h0000);
      nones_flags[i] = (wide || i < 2) && (value[i*16 +: 16] != 16'hffff);
    end
    nz      = 3'($countones(nz_flags));
    nones   = 3'($countones(nones_flags));
    zcost   = (nz == 3'd0) ? 3'd1 : nz;
    ncost   = (nones == 3'd0) ? 3'd1 : nones;
    inv     = allow_inv && (ncost < zcost);
    cost    = inv ? ncost : zcost;
    use_orr = allow_orr && (cost > 3'd1) && bitmask_imm(value, wide);
    sel     = inv ? nones_flags : nz_flags;

    // The seed lands on the lowest piece that needs it, or piece 0 if none does.
    first = '0;
    found = 1'b0;
    for (int i = 0; i < wim_pkg::NPIECES; i++) begin
      if (!found && sel[i]) begin
        first = wim_pkg::SLOT_W'(i);
        found = 1'b1;
      end
    end

    entry.value     = value;
    entry.wide      = wide;
    entry.dreg      = dreg;
    entry.use_orr   = use_orr;
    entry.inv       = inv;
    entry.first     = first;
    entry.keep_mask = use_orr ? '0 : (sel & ~(wim_pkg::NPIECES'(1) << first));
  end

endmodule

`default_nettype wire

[rtl/core/wim_queue.sv]
// Small queue of classified constants between the front and back ends.
`default_nettype none

module wim_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wim_pkg::entry_t      push_data,
  output logic                 full,
  input  wire logic            pop,
  output wim_pkg::entry_t      pop_data,
  output logic                 avail
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  wim_pkg::entry_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign avail    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

[rtl/core/wim_back.sv]
// Back end: issues the seed or OR instruction, then one move-keep per cycle while the result port is not stalled.
`default_nettype none

module wim_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wim_pkg::entry_t                    q_data,
  input  wire logic                          q_avail,
  output logic                               q_pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [wim_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic [wim_pkg::M_TUSER_W-1:0]      m_tuser,
  output logic                               m_tlast
);

  wim_pkg::entry_t             cur;
  logic                        act;
  logic [wim_pkg::NPIECES-1:0] rem;
  logic [wim_pkg::NPIECES-1:0] rem_next;
  logic [wim_pkg::SLOT_W-1:0]  kslot;
  logic                        out_free;
  logic                        do_keep;
  logic                        do_load;

  logic [1:0]                  o_kind;
  logic [wim_pkg::SLOT_W-1:0]  o_slot;
  logic [wim_pkg::VALUE_W-1:0] o_imm;
  logic                        o_wide;
  logic [wim_pkg::REG_W-1:0]   o_reg;
  logic                        o_last;

  logic [wim_pkg::PIECE_W-1:0] seed_piece;
  logic [wim_pkg::PIECE_W-1:0] keep_piece;

  assign out_free = !m_tvalid || m_tready;
  assign do_keep  = out_free && act;
  assign do_load  = out_free && !act && q_avail;
  assign q_pop    = do_load;

  always_comb begin
    kslot = '0;
    for (int i = wim_pkg::NPIECES - 1; i >= 0; i--) begin
      if (rem[i]) kslot = wim_pkg::SLOT_W'(i);
    end
    rem_next   = rem & ~(wim_pkg::NPIECES'(1) << kslot);
    seed_piece = q_data.value[{q_data.first, 4'b0000} +: 16];
    keep_piece = cur.value[{kslot, 4'b0000} +: 16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      act      <= 1'b0;
    end else if (out_free) begin
      if (act) begin
        m_tvalid <= 1'b1;
        act      <= (rem_next != '0);
      end else if (q_avail) begin
        m_tvalid <= 1'b1;
        act      <= (q_data.keep_mask != '0);
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_keep) begin
      rem    <= rem_next;
      o_kind <= wim_pkg::OP_MOVK;
      o_slot <= kslot;
      o_imm  <= {48'd0, keep_piece};
      o_wide <= cur.wide;
      o_reg  <= cur.dreg;
      o_last <= (rem_next == '0);
    end else if (do_load) begin
      cur    <= q_data;
      rem    <= q_data.keep_mask;
      o_wide <= q_data.wide;
      o_reg  <= q_data.dreg;
      o_last <= (q_data.keep_mask == '0);
      if (q_data.use_orr) begin
        o_kind <= wim_pkg::OP_ORR;
        o_slot <= '0;
        o_imm  <= q_data.value;
      end else if (q_data.inv) begin
        o_kind <= wim_pkg::OP_MOVN;
        o_slot <= q_data.first;
        o_imm  <= {48'd0, ~seed_piece};
      end else begin
        o_kind <= wim_pkg::OP_MOVZ;
        o_slot <= q_data.first;
        o_imm  <= {48'd0, seed_piece};
      end
    end
  end

  assign m_tdata = {1'b0, o_reg, o_imm, o_slot};
  assign m_tuser = {o_wide, o_kind};
  assign m_tlast = o_last;

endmodule

`default_nettype wire

[rtl/core/wide_immediate_materializer_core.sv]
// Top level of the wide immediate materializer: ports, configuration and wiring.
//
// Each accepted constant is turned into the shortest move-wide sequence that
// builds it: a single OR from the zero register when it is a bitmask immediate
// and the sequence would otherwise be longer, or a move-zero or move-inverted
// seed followed by one move-keep per remaining piece. A constant yields one to
// four results and the result port issues one per cycle unless m_tready stalls
// it; that port is the limit on sustained throughput. The input side
// classifies a constant in the cycle it is accepted and takes one per cycle
// while the queue of QUEUE_DEPTH entries has room; the first result is
// presented once the constant has passed the queue and the back end's output
// register. The last result of every constant is marked by m_tlast.
// Configuration registers may be written only while the block is idle.
`default_nettype none

module wide_immediate_materializer_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input stream.
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [wim_pkg::S_TDATA_W-1:0]    s_tdata,  // constant_value, dest_reg, zero pad
  input  wire logic                             s_tuser,  // is_wide
  // Result stream.
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [wim_pkg::M_TDATA_W-1:0]         m_tdata,  // piece_slot, imm_value, out_reg, zero pad
  output logic [wim_pkg::M_TUSER_W-1:0]         m_tuser,  // op_kind, out_wide
  output logic                                  m_tlast,  // last_of_run
  // Configuration write port.
  input  wire logic                             cfg_we,
  input  wire logic [wim_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic                             cfg_wdata
);

  logic            allow_inv;
  logic            allow_orr;
  logic            q_full;
  logic            q_avail;
  logic            q_pop;
  wim_pkg::entry_t front_entry;
  wim_pkg::entry_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_inv <= 1'b1;
      allow_orr <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        wim_pkg::REG_ALLOW_INV: allow_inv <= cfg_wdata;
        wim_pkg::REG_ALLOW_ORR: allow_orr <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s_tready = !q_full;

  wim_front u_front (
    .value_in  (s_tdata[63:0]),
    .wide      (s_tuser),
    .dreg      (s_tdata[68:64]),
    .allow_inv (allow_inv),
    .allow_orr (allow_orr),
    .entry     (front_entry)
  );

  wim_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .avail     (q_avail)
  );

  wim_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (q_data),
    .q_avail  (q_avail),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

[rtl/core/wim_checker.sv]
// Port-level checks on the materializer core's result stream, bound to the top level.
`default_nettype none

`include "wide_immediate_materializer_core_macros.svh"

module wim_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic [wim_pkg::M_TDATA_W-1:0] m_tdata,
  input  wire logic [wim_pkg::M_TUSER_W-1:0] m_tuser,
  input  wire logic                          m_tlast
);

  // A stalled result keeps its whole payload.
  `WIM_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

  // An OR instruction is always the whole sequence and sits in slot zero.
  `WIM_ASSERT_NOW(a_orr_alone, m_tvalid && m_tuser[1:0] == wim_pkg::OP_ORR, m_tlast && m_tdata[1:0] == 2'd0, "OR result not alone or not in slot zero")

  // A narrow register only has slots zero and one.
  `WIM_ASSERT_NOW(a_narrow_slot, m_tvalid && !m_tuser[2], m_tdata[1] == 1'b0, "narrow result addresses an upper slot")

  // Move instructions carry a 16-bit immediate only.
  `WIM_ASSERT_NOW(a_move_imm, m_tvalid && m_tuser[1:0] != wim_pkg::OP_ORR, m_tdata[65:18] == '0, "move immediate wider than one piece")

  // A narrow OR immediate never has bits above the register width.
  `WIM_ASSERT_NOW(a_narrow_orr, m_tvalid && m_tuser[1:0] == wim_pkg::OP_ORR && !m_tuser[2], m_tdata[65:34] == '0, "narrow OR immediate has high bits set")

endmodule

bind wide_immediate_materializer_core wim_checker u_wim_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
